[rtl/brq_pkg.sv]
// Shared constants, types and codes of the byte ring queue.
package brq_pkg;

    localparam int DEPTH     = 1024;
    localparam int GAP       = 8;
    localparam int MAX_BURST = 64;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int KIND_W  = 3;
    localparam int DATA_W  = 8;
    localparam int LEN_W   = 10;
    localparam int STAT_W  = 2;
    localparam int SIZE_W  = 11;
    localparam int BURST_W = $clog2(MAX_BURST + 1);
    localparam int CAP     = DEPTH - GAP;

    typedef enum logic [KIND_W-1:0] {
        K_WRITE   = 3'd0,
        K_READ    = 3'd1,
        K_PEEK    = 3'd2,
        K_DISCARD = 3'd3,
        K_COMMIT  = 3'd4,
        K_CLEAR   = 3'd5,
        K_QUERY   = 3'd6
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    typedef struct packed {
        t_kind              op;
        logic [DATA_W-1:0]  data;
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   need;
        logic [LEN_W-1:0]   off;
        logic               run_end;
        logic               too_long;
        logic               zero_len;
    } t_cmd;

endpackage

[rtl/brq_in_if.sv]
// Input word channel of the byte ring queue.
interface brq_in_if import brq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data_in;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  offset;
    logic              run_end;

    modport source (output valid, kind, data_in, length, offset, run_end, input ready);
    modport sink   (input valid, kind, data_in, length, offset, run_end, output ready);
endinterface

[rtl/brq_out_if.sv]
// Result word channel of the byte ring queue.
interface brq_out_if import brq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data_out;
    logic [LEN_W-1:0]  count;
    logic [LEN_W-1:0]  used_bytes;
    logic [LEN_W-1:0]  free_bytes;
    logic [SIZE_W-1:0] contiguous_free;
    logic [SIZE_W-1:0] contiguous_used;
    logic              last;

    modport source (output valid, status, data_out, count, used_bytes, free_bytes,
                    contiguous_free, contiguous_used, last, input ready);
    modport sink   (input valid, status, data_out, count, used_bytes, free_bytes,
                    contiguous_free, contiguous_used, last, output ready);
endinterface

[rtl/brq_front.sv]
// Front end: takes input words and decodes them into queue commands.
module brq_front import brq_pkg::*; (
    brq_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_cmd          = '0;
        o_cmd.data     = i_in.data_in;
        o_cmd.len      = i_in.length;
        o_cmd.off      = i_in.offset;
        o_cmd.run_end  = i_in.run_end;
        o_cmd.zero_len = (i_in.length == '0);
        o_cmd.need     = (i_in.length == '0) ? LEN_W'(1) : i_in.length;
        o_cmd.too_long = (i_in.length > LEN_W'(MAX_BURST));
        unique case (i_in.kind)
            K_WRITE:   o_cmd.op = K_WRITE;
            K_READ:    o_cmd.op = K_READ;
            K_PEEK:    o_cmd.op = K_PEEK;
            K_DISCARD: o_cmd.op = K_DISCARD;
            K_COMMIT:  o_cmd.op = K_COMMIT;
            K_CLEAR:   o_cmd.op = K_CLEAR;
            default:   o_cmd.op = K_QUERY;
        endcase
    end

endmodule

[rtl/brq_queue.sv]
// Two-entry command queue between front end and back end.
module brq_queue import brq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_ent [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_ent[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_valid)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop && o_valid) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/brq_back.sv]
// Back end: ring storage, pointers, run tracking and result words.
module brq_back import brq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    brq_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_SEND  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [PTR_W-1:0]    r_rp, r_wp, n_rp, n_wp;
    logic [PTR_W-1:0]    r_used, n_used;
    logic                r_run_act, r_run_rej, n_run_act, n_run_rej;
    logic [PTR_W-1:0]    r_addr, n_addr;
    logic [BURST_W-1:0]  r_left, n_left;
    logic [BURST_W-1:0]  r_n, n_n;
    logic                r_ov, n_ov;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [DATA_W-1:0]   r_data, n_data;
    logic [LEN_W-1:0]    r_count, n_count;
    logic                r_last, n_last;
    logic [DATA_W-1:0]   r_rdata;
    logic [DATA_W-1:0]   r_mem [DEPTH];

    logic                out_free;
    logic                mem_we;
    logic [PTR_W-1:0]    free_b;
    logic [PTR_W-1:0]    avail;
    logic [LEN_W-1:0]    peek_n;
    logic                rej;
    logic [PTR_W:0]      cf_lim, cu_lim;

    assign out_free = !r_ov || o_out.ready;
    assign free_b   = (r_used >= PTR_W'(CAP)) ? '0 : PTR_W'(CAP) - r_used;
    assign avail    = (PTR_W'(i_cmd.off) <= r_used) ? r_used - PTR_W'(i_cmd.off) : '0;
    assign peek_n   = (i_cmd.len < LEN_W'(avail)) ? i_cmd.len : LEN_W'(avail);
    assign rej      = r_run_act ? r_run_rej : (i_cmd.need > LEN_W'(free_b));

    always_comb begin
        n_state   = r_state;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_used    = r_used;
        n_run_act = r_run_act;
        n_run_rej = r_run_rej;
        n_addr    = r_addr;
        n_left    = r_left;
        n_n       = r_n;
        n_ov      = r_ov && !o_out.ready;
        n_status  = r_status;
        n_data    = r_data;
        n_count   = r_count;
        n_last    = r_last;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_pop    = 1'b1;
                    n_ov     = 1'b1;
                    n_status = ST_OK;
                    n_data   = '0;
                    n_count  = '0;
                    n_last   = 1'b1;
                    unique case (i_cmd.op)
                        K_WRITE: begin
                            if (rej || free_b == '0) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                mem_we  = 1'b1;
                                n_wp    = r_wp + PTR_W'(1);
                                n_used  = r_used + PTR_W'(1);
                                n_count = LEN_W'(1);
                            end
                            n_run_act = !i_cmd.run_end;
                            n_run_rej = !i_cmd.run_end && rej;
                        end
                        K_READ: begin
                            if (i_cmd.too_long) begin
                                n_status = ST_TOO_LONG;
                            end else if (i_cmd.len > LEN_W'(r_used)) begin
                                n_status = ST_UNDERFLOW;
                            end else if (!i_cmd.zero_len) begin
                                n_ov    = 1'b0;
                                n_rp    = r_rp + PTR_W'(i_cmd.len);
                                n_used  = r_used - PTR_W'(i_cmd.len);
                                n_addr  = r_rp;
                                n_left  = BURST_W'(i_cmd.len);
                                n_n     = BURST_W'(i_cmd.len);
                                n_state = S_FETCH;
                            end
                        end
                        K_PEEK: begin
                            if (i_cmd.too_long) begin
                                n_status = ST_TOO_LONG;
                            end else if (peek_n != '0) begin
                                n_ov    = 1'b0;
                                n_addr  = r_rp + PTR_W'(i_cmd.off);
                                n_left  = BURST_W'(peek_n);
                                n_n     = BURST_W'(peek_n);
                                n_state = S_FETCH;
                            end
                        end
                        K_DISCARD: begin
                            if (i_cmd.len > LEN_W'(r_used)) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                n_rp    = r_rp + PTR_W'(i_cmd.len);
                                n_used  = r_used - PTR_W'(i_cmd.len);
                                n_count = i_cmd.len;
                            end
                        end
                        K_COMMIT: begin
                            if (i_cmd.len > LEN_W'(free_b)) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_wp    = r_wp + PTR_W'(i_cmd.len);
                                n_used  = r_used + PTR_W'(i_cmd.len);
                                n_count = i_cmd.len;
                            end
                        end
                        K_CLEAR: begin
                            n_rp      = '0;
                            n_wp      = '0;
                            n_used    = '0;
                            n_run_act = 1'b0;
                            n_run_rej = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_status = ST_OK;
                    n_data   = r_rdata;
                    n_count  = LEN_W'(r_n);
                    n_last   = (r_left == BURST_W'(1));
                    n_addr   = r_addr + PTR_W'(1);
                    n_left   = r_left - BURST_W'(1);
                    n_state  = (r_left == BURST_W'(1)) ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rp      <= '0;
            r_wp      <= '0;
            r_used    <= '0;
            r_run_act <= 1'b0;
            r_run_rej <= 1'b0;
            r_left    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rp      <= n_rp;
            r_wp      <= n_wp;
            r_used    <= n_used;
            r_run_act <= n_run_act;
            r_run_rej <= n_run_rej;
            r_left    <= n_left;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_n      <= n_n;
        r_status <= n_status;
        r_data   <= n_data;
        r_count  <= n_count;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= i_cmd.data;
        end
        if (r_state == S_FETCH) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    // sizes track the pointers, which only move as a new word is loaded
    assign cf_lim = (PTR_W + 1)'(DEPTH) - {1'b0, r_wp};
    assign cu_lim = (PTR_W + 1)'(DEPTH) - {1'b0, r_rp};

    assign o_out.valid           = r_ov;
    assign o_out.status          = r_status;
    assign o_out.data_out        = r_data;
    assign o_out.count           = r_count;
    assign o_out.used_bytes      = LEN_W'(r_used);
    assign o_out.free_bytes      = LEN_W'(free_b);
    assign o_out.contiguous_free = (cf_lim > {1'b0, free_b}) ? SIZE_W'(free_b) : SIZE_W'(cf_lim);
    assign o_out.contiguous_used = (cu_lim > {1'b0, r_used}) ? SIZE_W'(r_used) : SIZE_W'(cu_lim);
    assign o_out.last            = r_last;

`ifndef SYNTHESIS
    a_used_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == PTR_W'(r_wp - r_rp)) else $error("used count out of step");
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= PTR_W'(CAP)) else $error("gap violated");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE && i_cmd_valid && out_free))
        else $error("pop outside idle");
    a_burst_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_left != '0)) else $error("empty burst in flight");
    a_burst_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && $past(r_state) != S_IDLE) |-> ($stable(r_rp) && $stable(r_wp)))
        else $error("pointers moved during burst");
`endif

endmodule

[rtl/byte_ring_queue_with_gap.sv]
// Byte ring queue with guard gap: front decode, command queue, back end.
// Path: an accepted word passes the command queue to the back end, whose
// result word is registered. Throughput: one word per cycle for write,
// discard, commit, clear and query while the output is taken; read and peek
// bursts pass a fetch and a send state per byte (storage read port).
// Reset: synchronous, active low; pointers, run state and queue cleared,
// storage contents left as they are.
module byte_ring_queue_with_gap import brq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    brq_in_if.sink    i_in,
    brq_out_if.source o_out
);

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd f_cmd;
    t_cmd q_cmd;

    brq_front u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (q_push),
        .o_cmd  (f_cmd)
    );

    brq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    brq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule
